// ----- sv/lnp_pkg.sv -----
`timescale 1ns / 1ps

package lnp_pkg;

    localparam int FIFO_DEPTH = 4;

    localparam logic [7:0] EXT_ESCAPE        = 8'd0;
    localparam logic [7:0] STD_ADVANCE_PC    = 8'd2;
    localparam logic [7:0] EXT_SET_ADDRESS   = 8'd2;
    localparam logic [7:0] SET_ADDR_LONG_LEN = 8'd9;

    localparam logic [3:0] ADDR_BYTES_LONG  = 4'd8;
    localparam logic [3:0] ADDR_BYTES_SHORT = 4'd4;

    localparam logic [7:0] RST_MIN_INST    = 8'd1;
    localparam logic [7:0] RST_LINE_BASE   = 8'hFB;
    localparam logic [7:0] RST_LINE_RANGE  = 8'd14;
    localparam logic [7:0] RST_OPCODE_BASE = 8'd13;

    localparam logic [31:0] LINE_START = 32'd1;

    localparam logic [1:0] REG_MIN_INST    = 2'd0;
    localparam logic [1:0] REG_LINE_BASE   = 2'd1;
    localparam logic [1:0] REG_LINE_RANGE  = 2'd2;
    localparam logic [1:0] REG_OPCODE_BASE = 2'd3;

    localparam logic KIND_ROW    = 1'b0;
    localparam logic KIND_NOTICE = 1'b1;

    typedef enum logic [2:0] {
        PH_OPCODE,
        PH_EXT_LEN,
        PH_EXT_OP,
        PH_ADDR,
        PH_ADV
    } t_phase;

    typedef enum logic [2:0] {
        OP_NOP,
        OP_SPECIAL,
        OP_NOTICE,
        OP_ADV,
        OP_ADDR_CLR,
        OP_ADDR_BYTE
    } t_op;

    typedef enum logic [1:0] {
        BS_IDLE,
        BS_DIV,
        BS_UPD
    } t_bstate;

    // command handed from the classifier to the executer
    typedef struct packed {
        logic       start;
        t_op        op;
        logic [7:0] data;   // adj, notice number, advance or address byte
        logic [2:0] shift;  // byte lane of an address byte
        logic       last;   // final address byte: emit a row
    } t_cmd;

endpackage

// ----- sv/lnp_fifo.sv -----
`timescale 1ns / 1ps

module lnp_fifo #(
    parameter int DEPTH = lnp_pkg::FIFO_DEPTH
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  lnp_pkg::t_cmd i_data,
    output logic         o_full,
    input  logic         i_pop,
    output lnp_pkg::t_cmd o_data,
    output logic         o_empty
);

    localparam int PW = $clog2(DEPTH);

    lnp_pkg::t_cmd r_mem [DEPTH];
    logic [PW-1:0] r_wptr;
    logic [PW-1:0] r_rptr;
    logic [PW:0]   r_count;

    assign o_full  = (r_count == (PW+1)'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (i_pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

// ----- sv/lnp_front.sv -----
`timescale 1ns / 1ps

module lnp_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  logic [7:0]    i_byte,
    input  logic          i_start,
    input  logic [7:0]    i_opcode_base,
    input  logic          i_full,
    output logic          o_push,
    output lnp_pkg::t_cmd o_cmd
);

    lnp_pkg::t_phase r_phase, n_phase, w_phase;
    logic [7:0] r_ext_len, n_ext_len;
    logic [3:0] r_bytes_left, n_bytes_left;
    logic [2:0] r_shift, n_shift;

    assign o_ready = !i_full;
    assign o_push  = i_valid && !i_full;
    assign w_phase = i_start ? lnp_pkg::PH_OPCODE : r_phase;

    // next state
    always_comb begin
        n_phase      = w_phase;
        n_ext_len    = r_ext_len;
        n_bytes_left = r_bytes_left;
        n_shift      = r_shift;
        unique case (w_phase)
            lnp_pkg::PH_EXT_LEN: begin
                n_ext_len = i_byte;
                n_phase   = lnp_pkg::PH_EXT_OP;
            end
            lnp_pkg::PH_EXT_OP: begin
                if (i_byte == lnp_pkg::EXT_SET_ADDRESS) begin
                    n_bytes_left = (r_ext_len == lnp_pkg::SET_ADDR_LONG_LEN)
                                 ? lnp_pkg::ADDR_BYTES_LONG : lnp_pkg::ADDR_BYTES_SHORT;
                    n_shift      = '0;
                    n_phase      = lnp_pkg::PH_ADDR;
                end else begin
                    n_phase = lnp_pkg::PH_OPCODE;
                end
            end
            lnp_pkg::PH_ADDR: begin
                n_bytes_left = r_bytes_left - 1'b1;
                n_shift      = r_shift + 1'b1;
                n_phase      = (r_bytes_left == 4'd1) ? lnp_pkg::PH_OPCODE : lnp_pkg::PH_ADDR;
            end
            lnp_pkg::PH_ADV: begin
                n_phase = lnp_pkg::PH_OPCODE;
            end
            default: begin
                if (i_byte == lnp_pkg::EXT_ESCAPE) begin
                    n_phase = lnp_pkg::PH_EXT_LEN;
                end else if (i_byte < i_opcode_base && i_byte == lnp_pkg::STD_ADVANCE_PC) begin
                    n_phase = lnp_pkg::PH_ADV;
                end else begin
                    n_phase = lnp_pkg::PH_OPCODE;
                end
            end
        endcase
    end

    // command out
    always_comb begin
        o_cmd.start = i_start;
        o_cmd.op    = lnp_pkg::OP_NOP;
        o_cmd.data  = i_byte;
        o_cmd.shift = r_shift;
        o_cmd.last  = (r_bytes_left == 4'd1);
        unique case (w_phase)
            lnp_pkg::PH_EXT_LEN: begin
                o_cmd.op = lnp_pkg::OP_NOP;
            end
            lnp_pkg::PH_EXT_OP: begin
                o_cmd.op = (i_byte == lnp_pkg::EXT_SET_ADDRESS)
                         ? lnp_pkg::OP_ADDR_CLR : lnp_pkg::OP_NOTICE;
            end
            lnp_pkg::PH_ADDR: begin
                o_cmd.op = lnp_pkg::OP_ADDR_BYTE;
            end
            lnp_pkg::PH_ADV: begin
                o_cmd.op = lnp_pkg::OP_ADV;
            end
            default: begin
                if (i_byte == lnp_pkg::EXT_ESCAPE) begin
                    o_cmd.op = lnp_pkg::OP_NOP;
                end else if (i_byte < i_opcode_base) begin
                    o_cmd.op = (i_byte == lnp_pkg::STD_ADVANCE_PC)
                             ? lnp_pkg::OP_NOP : lnp_pkg::OP_NOTICE;
                end else begin
                    o_cmd.op   = lnp_pkg::OP_SPECIAL;
                    o_cmd.data = i_byte - i_opcode_base;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= lnp_pkg::PH_OPCODE;
            r_ext_len    <= '0;
            r_bytes_left <= '0;
            r_shift      <= '0;
        end else if (o_push) begin
            r_phase      <= n_phase;
            r_ext_len    <= n_ext_len;
            r_bytes_left <= n_bytes_left;
            r_shift      <= n_shift;
        end
    end

endmodule

// ----- sv/lnp_back.sv -----
`timescale 1ns / 1ps

module lnp_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  lnp_pkg::t_cmd i_cmd,
    input  logic          i_empty,
    output logic          o_pop,
    input  logic [7:0]    i_min_inst,
    input  logic [7:0]    i_line_base,
    input  logic [7:0]    i_line_range,
    output logic          o_valid,
    input  logic          i_ready,
    output logic          o_kind,
    output logic [63:0]   o_addr,
    output logic [31:0]   o_line,
    output logic [7:0]    o_bad
);

    // one restoring step of the 8-bit divide
    function automatic logic [15:0] div_step(input logic [7:0] rem, input logic [7:0] quo,
                                             input logic [7:0] d);
        logic [8:0] t;
        logic [8:0] diff;
        t    = {rem, quo[7]};
        diff = t - {1'b0, d};
        if (t >= {1'b0, d}) begin
            return {diff[7:0], quo[6:0], 1'b1};
        end
        return {t[7:0], quo[6:0], 1'b0};
    endfunction

    lnp_pkg::t_bstate r_state, n_state;
    logic [63:0] r_addr;
    logic [31:0] r_line;
    logic [7:0]  r_quo;
    logic [7:0]  r_rem;
    logic [1:0]  r_cnt;
    logic        r_out_valid;
    logic        r_out_kind;
    logic [63:0] r_out_addr;
    logic [31:0] r_out_line;
    logic [7:0]  r_out_bad;

    logic [7:0]  w_div;
    logic [15:0] w_step1, w_step2;
    logic [63:0] w_base_addr, w_addr_or, w_upd_addr;
    logic [31:0] w_base_line, w_upd_line;
    logic [15:0] w_prod;
    logic        w_slot_free;
    logic        w_emit;

    assign w_div       = (i_line_range == '0) ? 8'd1 : i_line_range;
    assign w_step1     = div_step(r_rem, r_quo, w_div);
    assign w_step2     = div_step(w_step1[15:8], w_step1[7:0], w_div);
    assign w_base_addr = i_cmd.start ? '0 : r_addr;
    assign w_base_line = i_cmd.start ? lnp_pkg::LINE_START : r_line;
    assign w_addr_or   = w_base_addr | (64'(i_cmd.data) << {i_cmd.shift, 3'b000});
    assign w_prod      = i_min_inst * r_quo;
    assign w_upd_addr  = r_addr + 64'(w_prod);
    assign w_upd_line  = r_line + {{24{i_line_base[7]}}, i_line_base} + {24'd0, r_rem};
    assign w_slot_free = !r_out_valid || i_ready;

    // a beat is loaded into the output register this cycle
    assign w_emit = ((r_state == lnp_pkg::BS_IDLE) && o_pop
                     && ((i_cmd.op == lnp_pkg::OP_NOTICE)
                         || ((i_cmd.op == lnp_pkg::OP_ADDR_BYTE) && i_cmd.last)))
                  || (r_state == lnp_pkg::BS_UPD);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            lnp_pkg::BS_IDLE: begin
                if (o_pop && i_cmd.op == lnp_pkg::OP_SPECIAL) begin
                    n_state = lnp_pkg::BS_DIV;
                end
            end
            lnp_pkg::BS_DIV: begin
                if (r_cnt == 2'd3) begin
                    n_state = lnp_pkg::BS_UPD;
                end
            end
            lnp_pkg::BS_UPD: begin
                n_state = lnp_pkg::BS_IDLE;
            end
            default: begin
                n_state = lnp_pkg::BS_IDLE;
            end
        endcase
    end

    // outputs
    always_comb begin
        o_pop = (r_state == lnp_pkg::BS_IDLE) && !i_empty && w_slot_free;
    end

    assign o_valid = r_out_valid;
    assign o_kind  = r_out_kind;
    assign o_addr  = r_out_addr;
    assign o_line  = r_out_line;
    assign o_bad   = r_out_bad;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= lnp_pkg::BS_IDLE;
            r_addr      <= '0;
            r_line      <= lnp_pkg::LINE_START;
            r_out_valid <= 1'b0;
            r_cnt       <= '0;
        end else begin
            r_state <= n_state;
            if (w_emit) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                lnp_pkg::BS_IDLE: begin
                    if (o_pop) begin
                        r_line <= w_base_line;
                        unique case (i_cmd.op)
                            lnp_pkg::OP_NOTICE: begin
                                r_addr      <= w_base_addr;
                                r_out_kind  <= lnp_pkg::KIND_NOTICE;
                                r_out_addr  <= '0;
                                r_out_line  <= '0;
                                r_out_bad   <= i_cmd.data;
                            end
                            lnp_pkg::OP_ADV: begin
                                r_addr <= w_base_addr + 64'(i_cmd.data);
                            end
                            lnp_pkg::OP_ADDR_CLR: begin
                                r_addr <= '0;
                            end
                            lnp_pkg::OP_ADDR_BYTE: begin
                                r_addr <= w_addr_or;
                                if (i_cmd.last) begin
                                    r_out_kind  <= lnp_pkg::KIND_ROW;
                                    r_out_addr  <= w_addr_or;
                                    r_out_line  <= w_base_line;
                                    r_out_bad   <= '0;
                                end
                            end
                            lnp_pkg::OP_SPECIAL: begin
                                r_addr <= w_base_addr;
                                r_quo  <= i_cmd.data;
                                r_rem  <= '0;
                                r_cnt  <= '0;
                            end
                            default: begin
                                r_addr <= w_base_addr;
                            end
                        endcase
                    end
                end
                lnp_pkg::BS_DIV: begin
                    r_rem <= w_step2[15:8];
                    r_quo <= w_step2[7:0];
                    r_cnt <= r_cnt + 1'b1;
                end
                lnp_pkg::BS_UPD: begin
                    r_addr      <= w_upd_addr;
                    r_line      <= w_upd_line;
                    r_out_kind  <= lnp_pkg::KIND_ROW;
                    r_out_addr  <= w_upd_addr;
                    r_out_line  <= w_upd_line;
                    r_out_bad   <= '0;
                end
                default: begin
                end
            endcase
        end
    end

endmodule

// ----- sv/line_number_program_decoder.sv -----
`timescale 1ns / 1ps

// Line-program decoder. Program bytes arrive one per beat on the s_axis
// channel (tdata = program byte, tuser = start mark that clears address and
// line and restarts opcode parsing). Rows and opcode notices leave on the
// m_axis channel: tuser is the kind (0 row, 1 notice), tdata carries the row
// address, row line and notice number. The four decode registers sit on the
// APB port; the user must write them only while no byte is in flight; the
// block itself does not enforce this. A front stage classifies each byte
// against the parse phase at one byte a cycle while the queue is not full
// and queues a command; the back stage executes commands in order and loads
// results into the output register. A special opcode runs a divide by the
// line range (2 quotient bits a cycle) and the address/line update before
// the next command is taken. A stalled m_axis output holds its beat; the
// command queue keeps accepting bytes until it fills, then s_axis tready
// drops. Reset restores the register defaults, address 0, line 1, opcode
// phase, and empties the queue and the output stage.

module line_number_program_decoder #(
    parameter int FIFO_DEPTH = lnp_pkg::FIFO_DEPTH
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    input  logic [7:0]   i_s_axis_tdata,   // [7:0] data_byte
    input  logic         i_s_axis_tuser,   // [0] program_start
    output logic         o_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    output logic [103:0] o_m_axis_tdata,   // [63:0] row_address, [95:64] row_line,
                                           // [103:96] bad_opcode
    output logic         o_m_axis_tuser,   // [0] kind
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [3:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    logic [7:0] r_min_inst;
    logic [7:0] r_line_base;
    logic [7:0] r_line_range;
    logic [7:0] r_opcode_base;

    lnp_pkg::t_cmd w_push_cmd, w_pop_cmd;
    logic w_push, w_pop, w_full, w_empty;
    logic        w_kind;
    logic [63:0] w_addr;
    logic [31:0] w_line;
    logic [7:0]  w_bad;

    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_inst    <= lnp_pkg::RST_MIN_INST;
            r_line_base   <= lnp_pkg::RST_LINE_BASE;
            r_line_range  <= lnp_pkg::RST_LINE_RANGE;
            r_opcode_base <= lnp_pkg::RST_OPCODE_BASE;
        end else if (psel && penable && pwrite && pready) begin
            unique case (paddr[3:2])
                lnp_pkg::REG_MIN_INST:    r_min_inst    <= pwdata[7:0];
                lnp_pkg::REG_LINE_BASE:   r_line_base   <= pwdata[7:0];
                lnp_pkg::REG_LINE_RANGE:  r_line_range  <= pwdata[7:0];
                lnp_pkg::REG_OPCODE_BASE: r_opcode_base <= pwdata[7:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            lnp_pkg::REG_MIN_INST:    prdata = {24'd0, r_min_inst};
            lnp_pkg::REG_LINE_BASE:   prdata = {24'd0, r_line_base};
            lnp_pkg::REG_LINE_RANGE:  prdata = {24'd0, r_line_range};
            lnp_pkg::REG_OPCODE_BASE: prdata = {24'd0, r_opcode_base};
            default:                  prdata = '0;
        endcase
    end

    lnp_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_s_axis_tvalid),
        .o_ready       (o_s_axis_tready),
        .i_byte        (i_s_axis_tdata),
        .i_start       (i_s_axis_tuser),
        .i_opcode_base (r_opcode_base),
        .i_full        (w_full),
        .o_push        (w_push),
        .o_cmd         (w_push_cmd)
    );

    lnp_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_push_cmd),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_data  (w_pop_cmd),
        .o_empty (w_empty)
    );

    lnp_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_pop_cmd),
        .i_empty      (w_empty),
        .o_pop        (w_pop),
        .i_min_inst   (r_min_inst),
        .i_line_base  (r_line_base),
        .i_line_range (r_line_range),
        .o_valid      (o_m_axis_tvalid),
        .i_ready      (i_m_axis_tready),
        .o_kind       (w_kind),
        .o_addr       (w_addr),
        .o_line       (w_line),
        .o_bad        (w_bad)
    );

    assign o_m_axis_tdata = {w_bad, w_line, w_addr};
    assign o_m_axis_tuser = w_kind;

`ifndef SYNTHESIS
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> !w_empty)
        else $error("command popped from empty queue");

    a_notice_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tuser == lnp_pkg::KIND_NOTICE)
            |-> o_m_axis_tdata[95:0] == '0)
        else $error("notice carries row fields");

    a_row_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tuser == lnp_pkg::KIND_ROW)
            |-> o_m_axis_tdata[103:96] == '0)
        else $error("row carries an opcode number");

    a_queue_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_full && !w_pop) |=> w_full)
        else $error("queue drained without a pop");
`endif

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 1ps

module tb;

    localparam int STALL_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 12;
    localparam int RANDOM_BYTES = 1600;
    localparam int SEGMENTS     = 6;

    typedef struct packed {
        logic        kind;
        logic [63:0] address;
        logic [31:0] line;
        logic [7:0]  opcode;
    } t_decode_result;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         s_tvalid = 1'b0;
    logic [7:0]   s_tdata = 8'd0;
    logic         s_tuser = 1'b0;
    logic         m_tready = 1'b0;
    logic         psel = 1'b0;
    logic         penable = 1'b0;
    logic         pwrite = 1'b0;
    logic [3:0]   paddr = 4'd0;
    logic [31:0]  pwdata = 32'd0;
    logic         o_s_axis_tready;
    logic         o_m_axis_tvalid;
    logic [103:0] o_m_axis_tdata;
    logic         o_m_axis_tuser;
    logic [31:0]  prdata;
    logic         pready;

    // decoder copy: configuration
    logic [7:0]  cfg_min_inst    = lnp_pkg::RST_MIN_INST;
    logic [7:0]  cfg_line_base   = lnp_pkg::RST_LINE_BASE;
    logic [7:0]  cfg_line_range  = lnp_pkg::RST_LINE_RANGE;
    logic [7:0]  cfg_opcode_base = lnp_pkg::RST_OPCODE_BASE;
    // decoder copy: state
    lnp_pkg::t_phase ph = lnp_pkg::PH_OPCODE;
    logic [63:0] cur_addr = 64'd0;
    logic [31:0] cur_line = lnp_pkg::LINE_START;
    logic [7:0]  ext_len = 8'd0;
    logic [3:0]  addr_left = 4'd0;
    logic [5:0]  addr_shift = 6'd0;

    t_decode_result pending_results[$];
    int errors = 0;
    int bytes_sent = 0;
    int stall_cycles = 0;
    int snd_idle = 0;
    int rcv_idle = 0;

    line_number_program_decoder dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic t_decode_result make_row();
        t_decode_result r;
        r.kind    = lnp_pkg::KIND_ROW;
        r.address = cur_addr;
        r.line    = cur_line;
        r.opcode  = 8'd0;
        return r;
    endfunction

    function automatic t_decode_result make_notice(input logic [7:0] op);
        t_decode_result r;
        r.kind    = lnp_pkg::KIND_NOTICE;
        r.address = 64'd0;
        r.line    = 32'd0;
        r.opcode  = op;
        return r;
    endfunction

    function automatic logic start_mark();
        return $urandom_range(99) < 3;
    endfunction

    task automatic decode_byte(input logic [7:0] b, input logic start);
        logic [7:0] adj;
        logic [7:0] rng;
        if (start) begin
            cur_addr = 64'd0;
            cur_line = lnp_pkg::LINE_START;
            ph = lnp_pkg::PH_OPCODE;
        end
        case (ph)
            lnp_pkg::PH_EXT_LEN: begin
                ext_len = b;
                ph = lnp_pkg::PH_EXT_OP;
            end
            lnp_pkg::PH_EXT_OP: begin
                if (b == lnp_pkg::EXT_SET_ADDRESS) begin
                    addr_left = (ext_len == lnp_pkg::SET_ADDR_LONG_LEN)
                              ? lnp_pkg::ADDR_BYTES_LONG : lnp_pkg::ADDR_BYTES_SHORT;
                    addr_shift = 6'd0;
                    cur_addr = 64'd0;
                    ph = lnp_pkg::PH_ADDR;
                end else begin
                    ph = lnp_pkg::PH_OPCODE;
                    pending_results.push_back(make_notice(b));
                end
            end
            lnp_pkg::PH_ADDR: begin
                cur_addr = cur_addr | (64'(b) << addr_shift);
                addr_shift = addr_shift + 6'd8;
                addr_left = addr_left - 4'd1;
                if (addr_left == 4'd0) begin
                    ph = lnp_pkg::PH_OPCODE;
                    pending_results.push_back(make_row());
                end
            end
            lnp_pkg::PH_ADV: begin
                cur_addr = cur_addr + 64'(b);
                ph = lnp_pkg::PH_OPCODE;
            end
            default: begin
                ph = lnp_pkg::PH_OPCODE;
                if (b == lnp_pkg::EXT_ESCAPE) begin
                    ph = lnp_pkg::PH_EXT_LEN;
                end else if (b < cfg_opcode_base) begin
                    if (b == lnp_pkg::STD_ADVANCE_PC) ph = lnp_pkg::PH_ADV;
                    else pending_results.push_back(make_notice(b));
                end else begin
                    adj = b - cfg_opcode_base;
                    rng = (cfg_line_range == 8'd0) ? 8'd1 : cfg_line_range;
                    cur_addr = cur_addr + 64'(cfg_min_inst) * 64'(adj / rng);
                    cur_line = cur_line + {{24{cfg_line_base[7]}}, cfg_line_base}
                               + 32'(adj % rng);
                    pending_results.push_back(make_row());
                end
            end
        endcase
    endtask

    task automatic send_byte(input logic [7:0] b, input logic start);
        while ($urandom_range(99) < snd_idle) begin
            s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tuser  <= start;
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        decode_byte(b, start);
        bytes_sent++;
    endtask

    task automatic wait_results_drained();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // write, then read back the same register
    task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
        @(posedge i_clk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= {idx, 2'b00};
        pwdata  <= {24'd0, val};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        case (idx)
            lnp_pkg::REG_MIN_INST:    cfg_min_inst = val;
            lnp_pkg::REG_LINE_BASE:   cfg_line_base = val;
            lnp_pkg::REG_LINE_RANGE:  cfg_line_range = val;
            lnp_pkg::REG_OPCODE_BASE: cfg_opcode_base = val;
            default: begin
            end
        endcase
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        if (prdata[7:0] !== val) begin
            $error("register %0d readback: expected %h, got %h", idx, val, prdata[7:0]);
            errors++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic write_config(input logic [7:0] min_inst, input logic [7:0] lbase,
                                input logic [7:0] lrange, input logic [7:0] first_special);
        wait_results_drained();
        write_reg(lnp_pkg::REG_MIN_INST, min_inst);
        write_reg(lnp_pkg::REG_LINE_BASE, lbase);
        write_reg(lnp_pkg::REG_LINE_RANGE, lrange);
        write_reg(lnp_pkg::REG_OPCODE_BASE, first_special);
    endtask

    // one well-formed operation with random content, or noise
    task automatic send_random_op();
        int pick;
        logic [7:0] len;
        pick = $urandom_range(99);
        if (pick < 40) begin
            send_byte(cfg_opcode_base + 8'($urandom_range(255 - cfg_opcode_base)),
                      start_mark());
        end else if (pick < 52) begin
            send_byte(lnp_pkg::STD_ADVANCE_PC, start_mark());
            send_byte(8'($urandom), start_mark());
        end else if (pick < 67) begin
            len = $urandom_range(1) ? lnp_pkg::SET_ADDR_LONG_LEN : 8'($urandom);
            send_byte(lnp_pkg::EXT_ESCAPE, start_mark());
            send_byte(len, start_mark());
            send_byte(lnp_pkg::EXT_SET_ADDRESS, start_mark());
            repeat ((len == lnp_pkg::SET_ADDR_LONG_LEN) ? 8 : 4)
                send_byte(8'($urandom), start_mark());
        end else if (pick < 75) begin
            send_byte(lnp_pkg::EXT_ESCAPE, start_mark());
            send_byte(8'($urandom), start_mark());
            send_byte(8'($urandom), start_mark());
        end else if (pick < 85) begin
            if (cfg_opcode_base > 8'd1)
                send_byte(8'($urandom_range(cfg_opcode_base - 1, 1)), start_mark());
            else
                send_byte(8'($urandom), start_mark());
        end else begin
            send_byte(8'($urandom), start_mark());
        end
    endtask

    task automatic test_default_program();
        send_byte(8'd255, 1'b1);
        send_byte(8'd13, 1'b0);
        send_byte(8'd1, 1'b0);
        send_byte(lnp_pkg::STD_ADVANCE_PC, 1'b0);
        send_byte(8'hFF, 1'b0);
        // long set_address near the top, then a special opcode wraps it
        send_byte(lnp_pkg::EXT_ESCAPE, 1'b0);
        send_byte(lnp_pkg::SET_ADDR_LONG_LEN, 1'b0);
        send_byte(lnp_pkg::EXT_SET_ADDRESS, 1'b0);
        send_byte(8'hF0, 1'b0);
        repeat (7) send_byte(8'hFF, 1'b0);
        send_byte(8'd255, 1'b0);
        send_byte(lnp_pkg::EXT_ESCAPE, 1'b0);
        send_byte(8'd5, 1'b0);
        send_byte(lnp_pkg::EXT_SET_ADDRESS, 1'b0);
        send_byte(8'hDD, 1'b0);
        send_byte(8'hCC, 1'b0);
        send_byte(8'hBB, 1'b0);
        send_byte(8'hAA, 1'b0);
        // extended op 1: sequence end, reported only
        send_byte(lnp_pkg::EXT_ESCAPE, 1'b0);
        send_byte(8'd1, 1'b0);
        send_byte(8'd1, 1'b0);
        // start mark cuts an extended op short
        send_byte(lnp_pkg::EXT_ESCAPE, 1'b0);
        send_byte(8'd34, 1'b1);
    endtask

    task automatic test_degenerate_config();
        write_config(8'd255, 8'h80, 8'd0, 8'd0);
        send_byte(8'd1, 1'b1);
        send_byte(lnp_pkg::EXT_ESCAPE, 1'b0);
        send_byte(8'd7, 1'b0);
        send_byte(8'd3, 1'b0);
        send_byte(8'd200, 1'b0);
    endtask

    task automatic test_random_programs();
        int target;
        for (int k = 0; k < SEGMENTS; k++) begin
            snd_idle = (k < 2) ? 11 : (k < 4) ? 81 : 0;
            rcv_idle = (k < 2) ? 81 : (k < 4) ? 11 : 0;
            case (k)
                0: write_config(lnp_pkg::RST_MIN_INST, lnp_pkg::RST_LINE_BASE,
                                lnp_pkg::RST_LINE_RANGE, lnp_pkg::RST_OPCODE_BASE);
                1: write_config(8'd255, 8'h7F, 8'd255, 8'd255);
                2: write_config(8'd0, 8'h80, 8'd1, 8'd1);
                4: write_config(8'($urandom), 8'($urandom), 8'd0, 8'd0);
                default: write_config(8'($urandom), 8'($urandom),
                                      8'($urandom_range(255, 1)), 8'($urandom_range(40, 1)));
            endcase
            target = bytes_sent + RANDOM_BYTES / SEGMENTS;
            while (bytes_sent < target) begin
                send_random_op();
                if ($urandom_range(99) == 0) wait_results_drained();
            end
        end
    endtask

    always @(posedge i_clk) begin : check_results
        t_decode_result want;
        m_tready <= ($urandom_range(99) >= rcv_idle);
        if (i_rst_n && o_m_axis_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                $error("unexpected result beat: kind %0b, tdata %h",
                       o_m_axis_tuser, o_m_axis_tdata);
                errors++;
            end else begin
                want = pending_results.pop_front();
                if (o_m_axis_tuser !== want.kind) begin
                    $error("kind: expected %0b, got %0b", want.kind, o_m_axis_tuser);
                    errors++;
                end
                if (o_m_axis_tdata[63:0] !== want.address) begin
                    $error("row_address: expected %h, got %h",
                           want.address, o_m_axis_tdata[63:0]);
                    errors++;
                end
                if (o_m_axis_tdata[95:64] !== want.line) begin
                    $error("row_line: expected %h, got %h", want.line, o_m_axis_tdata[95:64]);
                    errors++;
                end
                if (o_m_axis_tdata[103:96] !== want.opcode) begin
                    $error("bad_opcode: expected %h, got %h",
                           want.opcode, o_m_axis_tdata[103:96]);
                    errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((s_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && m_tready) || psel)
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        snd_idle = 11;
        rcv_idle = 81;
        test_default_program();
        test_degenerate_config();
        test_random_programs();
        wait_results_drained();
        if (errors == 0 && pending_results.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

// ----- filelist.f -----
sv/lnp_pkg.sv
sv/lnp_fifo.sv
sv/lnp_front.sv
sv/lnp_back.sv
sv/line_number_program_decoder.sv
tb/tb.sv
